[design/sqd_pkg.sv]
// Package for the shortest-queue dispatcher: field widths, codes, defaults
// and the command and status structs between controller and datapath.
// Depends on nothing.
package sqd_pkg;

   localparam int NUM_SERVERS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int REP_W           = $clog2(MAX_RESULTS);

   localparam int KIND_W  = 2;
   localparam int TAG_W   = 16;
   localparam int SVC_W   = 12;
   localparam int SIDX_W  = 3;
   localparam int ENT_W   = TAG_W + SVC_W;
   localparam int EV_W    = 3;
   localparam int CLK_W   = 32;
   localparam int CSR_W   = 4;
   localparam int REQ_W   = 32;
   localparam int RSP_W   = 56;
   localparam int SVC_MAX = (1 << SVC_W) - 1;

   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ARRIVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REOPEN = 2'd3;

   localparam logic [EV_W-1:0] EV_DEPART   = 3'd0;
   localparam logic [EV_W-1:0] EV_PLACED   = 3'd1;
   localparam logic [EV_W-1:0] EV_ARR_REJ  = 3'd2;
   localparam logic [EV_W-1:0] EV_MOVED    = 3'd3;
   localparam logic [EV_W-1:0] EV_MOVE_REJ = 3'd4;
   localparam logic [EV_W-1:0] EV_STATE    = 3'd5;

   localparam logic [1:0] ST_CLOSED = 2'd0;
   localparam logic [1:0] ST_DRAIN  = 2'd1;
   localparam logic [1:0] ST_OPEN   = 2'd2;

   typedef struct packed {
      logic accept;
      logic tick_rd;
      logic tick_upd;
      logic scan_step;
      logic enq;
      logic enq_move;
      logic enq_emit;
      logic cl_start;
      logic cl_rd;
      logic emit_state;
      logic reopen;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic tk_done;
      logic depart;
      logic scan_last;
      logic in_range;
      logic cnt_zero;
      logic move_more;
      logic report_ok;
      logic can_emit;
      logic out_free;
      logic hold_v;
   } sts_type;

endpackage

[design/shortest_queue_dispatcher.sv]
// Top level of the join-shortest-queue dispatcher.
// Joins sqd_ctrl and sqd_dp; depends on sqd_pkg.
//
// Items enter on the req_ channel: req_tuser carries the kind (tick, arrival,
// close, reopen), req_tdata the tag, service time and server index. Results
// leave on the rsp_ channel with the event code in rsp_tuser and rsp_tlast
// on the final result of an item. The csr_ channel writes the number of
// servers in use; it is always ready and must be written only while idle.
// One item is worked on at a time. An arrival runs the serial scan for the
// shortest open queue over the servers in use and then enqueues the item.
// A tick does one memory read and one update per server in use. A close
// repeats the scan and the enqueue for every entry it moves; a reopen needs
// neither. The block returns to idle before the next item is taken.
// Items with no result finish without touching the rsp_ channel.
// The last result is held back in a hold register so that rsp_tlast can be set; an output
// register parts the channels, so a new item is accepted while the final
// result still waits. A stalled receiver only holds the block where a
// further result must be stored. Reset opens all servers, empties all
// queues, clears the tick clock and sets the servers in use to eight; the
// queue memory itself is not cleared.
module shortest_queue_dispatcher #(
   parameter int NUM_SERVERS = sqd_pkg::NUM_SERVERS_DEF,
   parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // customer_tag [15:0], service_time [27:16], server_index [30:28]
   input  logic [sqd_pkg::REQ_W-1:0]     req_tdata,
   // kind [1:0]
   input  logic [sqd_pkg::KIND_W-1:0]    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tag_out [15:0], server_out [18:16], clock_out [50:19]
   output logic [sqd_pkg::RSP_W-1:0]     rsp_tdata,
   // event_res [2:0]
   output logic [sqd_pkg::EV_W-1:0]      rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sqd_pkg::CSR_W-1:0]     csr_data
);
   import sqd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   sqd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sqd_dp #(
      .NUM_SERVERS (NUM_SERVERS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_kind   (req_tuser),
      .req_data   (req_tdata),
      .csr_we     (csr_valid && csr_ready),
      .csr_wdata  (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while the previous one is still at work");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= EV_STATE)
      else $error("result carries an undefined event code");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick_upd && sts.depart) || cmd.emit_state || cmd.flush |-> sts.can_emit)
      else $error("result stored with no room in the output path");

   a_idle_flushed: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.hold_v)
      else $error("held result left behind when the block went idle");

endmodule

[design/sqd_ctrl.sv]
// Controller state machine of the shortest-queue dispatcher.
// Sequences ticks, arrivals, closes and reopens; depends on sqd_pkg.
module sqd_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic [sqd_pkg::KIND_W-1:0]    req_kind,
   output logic                          req_tready,
   input  sqd_pkg::sts_type              sts,
   output sqd_pkg::cmd_type              cmd
);
   import sqd_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_TK_RD    = 4'd1;
   localparam logic [3:0] S_TK_CHK   = 4'd2;
   localparam logic [3:0] S_SCAN     = 4'd3;
   localparam logic [3:0] S_ENQ      = 4'd4;
   localparam logic [3:0] S_CL_START = 4'd5;
   localparam logic [3:0] S_CL_RD    = 4'd6;
   localparam logic [3:0] S_CL_END   = 4'd7;
   localparam logic [3:0] S_REOPEN   = 4'd8;
   localparam logic [3:0] S_FLUSH    = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       move_ff, move_in;
   logic       need_emit;

   assign req_tready = (state_ff == S_IDLE);
   assign need_emit  = !move_ff || sts.report_ok;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      move_in  = move_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               case (req_kind)
                  KIND_TICK: state_in = S_TK_RD;
                  KIND_ARRIVE: begin
                     move_in  = 1'b0;
                     state_in = S_SCAN;
                  end
                  KIND_CLOSE: state_in = S_CL_START;
                  default: state_in = S_REOPEN;
               endcase
            end
         end
         S_TK_RD: begin
            if (sts.tk_done) begin
               state_in = S_FLUSH;
            end else begin
               cmd.tick_rd = 1'b1;
               state_in     = S_TK_CHK;
            end
         end
         S_TK_CHK: begin
            if (!sts.depart || sts.can_emit) begin
               cmd.tick_upd = 1'b1;
               state_in     = S_TK_RD;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_ENQ;
         end
         S_ENQ: begin
            if (!need_emit || sts.can_emit) begin
               cmd.enq      = 1'b1;
               cmd.enq_move = move_ff;
               cmd.enq_emit = need_emit;
               state_in     = move_ff ? S_CL_RD : S_FLUSH;
            end
         end
         S_CL_START: begin
            if (!sts.in_range) begin
               state_in = S_IDLE;
            end else begin
               cmd.cl_start = 1'b1;
               if (sts.cnt_zero) begin
                  state_in = S_CL_END;
               end else begin
                  move_in  = 1'b1;
                  state_in = S_CL_RD;
               end
            end
         end
         S_CL_RD: begin
            if (!sts.move_more) begin
               state_in = S_CL_END;
            end else begin
               cmd.cl_rd = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_CL_END: begin
            if (sts.can_emit) begin
               cmd.emit_state = 1'b1;
               state_in       = S_FLUSH;
            end
         end
         S_REOPEN: begin
            if (!sts.in_range) begin
               state_in = S_IDLE;
            end else if (sts.can_emit) begin
               cmd.reopen     = 1'b1;
               cmd.emit_state = 1'b1;
               state_in       = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!sts.hold_v) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         move_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         move_ff  <= move_in;
      end
   end

endmodule

[design/sqd_dp.sv]
// Datapath of the shortest-queue dispatcher: per-server state, the shared
// queue memory, the scan unit and the result hold and output registers.
// Depends on sqd_pkg.
module sqd_dp #(
   parameter int NUM_SERVERS = sqd_pkg::NUM_SERVERS_DEF,
   parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sqd_pkg::cmd_type              cmd,
   output sqd_pkg::sts_type              sts,
   input  logic [sqd_pkg::KIND_W-1:0]    req_kind,
   input  logic [sqd_pkg::REQ_W-1:0]     req_data,
   input  logic                          csr_we,
   input  logic [sqd_pkg::CSR_W-1:0]     csr_wdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sqd_pkg::RSP_W-1:0]     rsp_tdata,
   output logic [sqd_pkg::EV_W-1:0]      rsp_tuser,
   output logic                          rsp_tlast
);
   import sqd_pkg::*;

   localparam int SW  = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
   localparam int SCW = $clog2(NUM_SERVERS + 1);
   localparam int QW  = $clog2(QUEUE_DEPTH);
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int AW  = $clog2(NUM_SERVERS * QUEUE_DEPTH);
   localparam int MD  = NUM_SERVERS * QUEUE_DEPTH;

   logic [CSR_W-1:0]  csr_ff;
   logic [CLK_W-1:0]  tick_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [SVC_W-1:0]  svc_ff;
   logic [SIDX_W-1:0] sidx_ff;

   logic [1:0]        status_ff  [NUM_SERVERS];
   logic [QW-1:0]     head_ff    [NUM_SERVERS];
   logic [QW-1:0]     tail_ff    [NUM_SERVERS];
   logic [CW-1:0]     count_ff   [NUM_SERVERS];
   logic [SVC_W-1:0]  elapsed_ff [NUM_SERVERS];

   logic [ENT_W-1:0]  mem [MD];
   logic [ENT_W-1:0]  rd_data_ff;
   logic              mem_re, mem_we;
   logic [AW-1:0]     mem_raddr, mem_waddr;
   logic [ENT_W-1:0]  mem_wdata;

   logic [SCW-1:0]    srv_ff;
   logic              found_ff;
   logic [CW-1:0]     best_ff;
   logic [SCW-1:0]    sel_ff;
   logic [QW-1:0]     h_ff;
   logic [CW-1:0]     cnt_ff;
   logic [CW-1:0]     i_ff;
   logic [REP_W-1:0]  rep_ff;

   logic              hold_v_ff;
   logic [EV_W-1:0]   hold_ev_ff;
   logic [TAG_W-1:0]  hold_tag_ff;
   logic [SIDX_W-1:0] hold_srv_ff;
   logic [CLK_W-1:0]  hold_clk_ff;

   logic              out_v_ff;
   logic [EV_W-1:0]   out_ev_ff;
   logic [TAG_W-1:0]  out_tag_ff;
   logic [SIDX_W-1:0] out_srv_ff;
   logic [CLK_W-1:0]  out_clk_ff;
   logic              out_last_ff;

   int                n_act;
   logic [SW-1:0]     ix, six;
   logic [SVC_W-1:0]  el_nx;
   logic              depart;
   logic              cand;
   logic              enq_ok;
   logic [CW:0]       slot_sum;
   logic [QW-1:0]     slot;
   logic              emit;
   logic [EV_W-1:0]   emit_ev;
   logic [TAG_W-1:0]  emit_tag;
   logic [SIDX_W-1:0] emit_srv;
   logic [ENT_W-1:0]  enq_ent;

   function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
      ptr_inc = (int'(p) == QUEUE_DEPTH - 1) ? '0 : QW'(int'(p) + 1);
   endfunction

   always_comb begin
      if (csr_ff == '0) begin
         n_act = 1;
      end else if (int'(csr_ff) > NUM_SERVERS) begin
         n_act = NUM_SERVERS;
      end else begin
         n_act = int'(csr_ff);
      end
   end

   assign ix  = srv_ff[SW-1:0];
   assign six = SW'(sidx_ff);

   assign el_nx  = (elapsed_ff[ix] == SVC_W'(SVC_MAX)) ? elapsed_ff[ix] : elapsed_ff[ix] + 1'b1;
   assign depart = (count_ff[ix] != '0) && (status_ff[ix] != ST_CLOSED)
                   && (el_nx >= rd_data_ff[SVC_W-1:0]);
   assign cand   = (status_ff[ix] == ST_OPEN) && (!found_ff || count_ff[ix] < best_ff);
   assign enq_ok = found_ff && (int'(best_ff) < QUEUE_DEPTH);

   assign slot_sum = (CW+1)'(h_ff) + (CW+1)'(i_ff);
   assign slot     = (int'(slot_sum) >= QUEUE_DEPTH) ? QW'(int'(slot_sum) - QUEUE_DEPTH)
                                                     : QW'(slot_sum);
   assign enq_ent  = cmd.enq_move ? rd_data_ff : {tag_ff, svc_ff};

   always_comb begin
      mem_re    = cmd.tick_rd || cmd.cl_rd;
      mem_raddr = cmd.cl_rd ? AW'(int'(six) * QUEUE_DEPTH + int'(slot))
                            : AW'(int'(ix) * QUEUE_DEPTH + int'(head_ff[ix]));
      mem_we    = cmd.enq && enq_ok;
      mem_waddr = AW'(int'(ix) * QUEUE_DEPTH + int'(tail_ff[ix]));
      mem_wdata = enq_ent;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   always_comb begin
      emit     = 1'b0;
      emit_ev  = EV_STATE;
      emit_tag = '0;
      emit_srv = sidx_ff;
      if (cmd.tick_upd && depart) begin
         emit     = 1'b1;
         emit_ev  = EV_DEPART;
         emit_tag = rd_data_ff[ENT_W-1:SVC_W];
         emit_srv = SIDX_W'(srv_ff);
      end else if (cmd.enq && cmd.enq_emit) begin
         emit     = 1'b1;
         emit_tag = enq_ent[ENT_W-1:SVC_W];
         if (enq_ok) begin
            emit_ev  = cmd.enq_move ? EV_MOVED : EV_PLACED;
            emit_srv = SIDX_W'(srv_ff);
         end else begin
            emit_ev  = cmd.enq_move ? EV_MOVE_REJ : EV_ARR_REJ;
            emit_srv = '0;
         end
      end else if (cmd.emit_state) begin
         emit = 1'b1;
      end
   end

   always_comb begin
      sts           = '0;
      sts.tk_done   = (int'(srv_ff) == n_act);
      sts.depart    = depart;
      sts.scan_last = (int'(srv_ff) == n_act - 1);
      sts.in_range  = (int'(sidx_ff) < n_act);
      sts.cnt_zero  = (count_ff[six] == '0);
      sts.move_more = (i_ff < cnt_ff);
      sts.report_ok = (int'(rep_ff) < MAX_RESULTS - 1);
      sts.out_free  = !out_v_ff || rsp_tready;
      sts.can_emit  = !hold_v_ff || sts.out_free;
      sts.hold_v    = hold_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff    <= CSR_W'(NUM_SERVERS_DEF);
         tick_ff   <= '0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         srv_ff    <= '0;
         found_ff  <= 1'b0;
         for (int s = 0; s < NUM_SERVERS; s++) begin
            status_ff[s]  <= ST_OPEN;
            head_ff[s]    <= '0;
            tail_ff[s]    <= '0;
            count_ff[s]   <= '0;
            elapsed_ff[s] <= '0;
         end
      end else begin
         if (csr_we) csr_ff <= csr_wdata;

         if (cmd.accept) begin
            tag_ff   <= req_data[TAG_W-1:0];
            svc_ff   <= req_data[TAG_W+SVC_W-1:TAG_W];
            sidx_ff  <= req_data[ENT_W+SIDX_W-1:ENT_W];
            srv_ff   <= '0;
            found_ff <= 1'b0;
            if (req_kind == KIND_TICK) tick_ff <= tick_ff + 1'b1;
         end

         if (cmd.tick_upd) begin
            srv_ff <= srv_ff + 1'b1;
            if (count_ff[ix] != '0 && status_ff[ix] != ST_CLOSED) begin
               if (depart) begin
                  head_ff[ix]    <= ptr_inc(head_ff[ix]);
                  count_ff[ix]   <= count_ff[ix] - 1'b1;
                  elapsed_ff[ix] <= '0;
                  if (status_ff[ix] == ST_DRAIN) status_ff[ix] <= ST_CLOSED;
               end else begin
                  elapsed_ff[ix] <= el_nx;
               end
            end
         end

         if (cmd.scan_step) begin
            if (cand) begin
               found_ff <= 1'b1;
               best_ff  <= count_ff[ix];
               sel_ff   <= srv_ff;
            end
            if (int'(srv_ff) == n_act - 1) begin
               srv_ff <= cand ? srv_ff : sel_ff;
            end else begin
               srv_ff <= srv_ff + 1'b1;
            end
         end

         if (cmd.enq) begin
            if (enq_ok) begin
               tail_ff[ix]  <= ptr_inc(tail_ff[ix]);
               count_ff[ix] <= count_ff[ix] + 1'b1;
            end
            if (cmd.enq_move) begin
               i_ff <= i_ff + 1'b1;
               if (cmd.enq_emit) rep_ff <= rep_ff + 1'b1;
            end
         end

         if (cmd.cl_start) begin
            rep_ff <= '0;
            if (count_ff[six] == '0) begin
               status_ff[six] <= ST_CLOSED;
            end else begin
               status_ff[six] <= ST_DRAIN;
               h_ff           <= head_ff[six];
               cnt_ff         <= count_ff[six];
               i_ff           <= CW'(1);
               tail_ff[six]   <= ptr_inc(head_ff[six]);
               count_ff[six]  <= CW'(1);
            end
         end

         if (cmd.cl_rd) begin
            srv_ff   <= '0;
            found_ff <= 1'b0;
         end

         if (cmd.reopen) status_ff[six] <= ST_OPEN;

         if ((emit && hold_v_ff) || cmd.flush) begin
            out_v_ff <= 1'b1;
         end else if (out_v_ff && rsp_tready) begin
            out_v_ff <= 1'b0;
         end

         if (emit) begin
            if (hold_v_ff) begin
               out_ev_ff   <= hold_ev_ff;
               out_tag_ff  <= hold_tag_ff;
               out_srv_ff  <= hold_srv_ff;
               out_clk_ff  <= hold_clk_ff;
               out_last_ff <= 1'b0;
            end
            hold_v_ff   <= 1'b1;
            hold_ev_ff  <= emit_ev;
            hold_tag_ff <= emit_tag;
            hold_srv_ff <= emit_srv;
            hold_clk_ff <= tick_ff;
         end else if (cmd.flush) begin
            out_ev_ff   <= hold_ev_ff;
            out_tag_ff  <= hold_tag_ff;
            out_srv_ff  <= hold_srv_ff;
            out_clk_ff  <= hold_clk_ff;
            out_last_ff <= 1'b1;
            hold_v_ff   <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_ev_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {(RSP_W - CLK_W - SIDX_W - TAG_W)'(0), out_clk_ff, out_srv_ff, out_tag_ff};

endmodule

[tb/tb_shortest_queue_dispatcher.sv]
// Testbench for shortest_queue_dispatcher: directed items, then random items in
// phases with different server counts, checked against an in-bench predictor.
// Depends on sqd_pkg and the dispatcher RTL.
`timescale 1ns / 100ps

module tb_shortest_queue_dispatcher;
   import sqd_pkg::*;

   localparam int NSRV = NUM_SERVERS_DEF;
   localparam int QDEP = QUEUE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 4 * NSRV + 20;

   typedef struct {
      logic [EV_W-1:0]  ev;
      logic [TAG_W-1:0] tag;
      logic [2:0]       srv;
      logic [CLK_W-1:0] clk;
      logic             last;
   } dispatch_event_type;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [TAG_W-1:0]  tag;
      logic [SVC_W-1:0]  svc;
      logic [2:0]        sidx;
      bit                typed;
      logic [EV_W-1:0]   ev;
      logic [2:0]        srv;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [EV_W-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_W-1:0] csr_data = '0;

   shortest_queue_dispatcher u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Predictor state.
   logic [CSR_W-1:0] servers_reg;
   logic [1:0]       srv_state [NSRV];
   int unsigned      head_ptr [NSRV];
   int unsigned      tail_ptr [NSRV];
   int unsigned      fill [NSRV];
   logic [SVC_W-1:0] elapsed [NSRV];
   logic [ENT_W-1:0] slots [NSRV][QDEP];
   logic [CLK_W-1:0] ticks;

   dispatch_event_type pending_events[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  no_stall = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   function automatic int servers_active();
      int n;
      n = servers_reg;
      if (n < 1) n = 1;
      if (n > NSRV) n = NSRV;
      return n;
   endfunction

   function automatic int shortest_open();
      int best;
      int sel;
      best = QDEP + 1;
      sel = -1;
      for (int i = 0; i < servers_active(); i++)
         if (srv_state[i] == ST_OPEN && fill[i] < best) begin
            best = fill[i];
            sel = i;
         end
      return sel;
   endfunction

   function automatic int join_queue(input logic [ENT_W-1:0] entry);
      int s;
      s = shortest_open();
      if (s < 0) return -1;
      if (fill[s] >= QDEP) return -1;
      slots[s][tail_ptr[s]] = entry;
      tail_ptr[s] = (tail_ptr[s] + 1) % QDEP;
      fill[s]++;
      return s;
   endfunction

   task automatic add_event(input logic [EV_W-1:0] ev, input logic [TAG_W-1:0] tag,
                            input int srv);
      dispatch_event_type r;
      r.ev = ev;
      r.tag = tag;
      r.srv = srv[2:0];
      r.clk = ticks;
      r.last = 0;
      pending_events.push_back(r);
   endtask

   task automatic predict_dispatch(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] tag,
                                   input logic [SVC_W-1:0] svc, input logic [2:0] sidx);
      int n;
      int n_prior;
      int s;
      int moved;
      int cnt;
      int h;
      logic [ENT_W-1:0] e;
      n = servers_active();
      n_prior = pending_events.size();
      moved = 0;
      case (kind)
         KIND_TICK: begin
            ticks = ticks + 1;
            for (int i = 0; i < n; i++) begin
               if (fill[i] == 0 || srv_state[i] == ST_CLOSED) continue;
               if (elapsed[i] != SVC_MAX) elapsed[i]++;
               e = slots[i][head_ptr[i]];
               if (elapsed[i] >= e[SVC_W-1:0]) begin
                  add_event(EV_DEPART, e[ENT_W-1:SVC_W], i);
                  head_ptr[i] = (head_ptr[i] + 1) % QDEP;
                  fill[i]--;
                  elapsed[i] = 0;
                  if (srv_state[i] == ST_DRAIN) srv_state[i] = ST_CLOSED;
               end
            end
         end
         KIND_ARRIVE: begin
            s = join_queue({tag, svc});
            if (s < 0) add_event(EV_ARR_REJ, tag, 0);
            else add_event(EV_PLACED, tag, s);
         end
         KIND_CLOSE: begin
            if (sidx < n) begin
               if (fill[sidx] == 0) begin
                  srv_state[sidx] = ST_CLOSED;
               end else begin
                  cnt = fill[sidx];
                  h = head_ptr[sidx];
                  srv_state[sidx] = ST_DRAIN;
                  for (int i = 1; i < cnt; i++) begin
                     e = slots[sidx][(h + i) % QDEP];
                     s = join_queue(e);
                     if (moved < MAX_RESULTS - 1) begin
                        if (s < 0) add_event(EV_MOVE_REJ, e[ENT_W-1:SVC_W], 0);
                        else add_event(EV_MOVED, e[ENT_W-1:SVC_W], s);
                        moved++;
                     end
                  end
                  tail_ptr[sidx] = (h + 1) % QDEP;
                  fill[sidx] = 1;
               end
               add_event(EV_STATE, '0, sidx);
            end
         end
         default: begin
            if (sidx < n) begin
               srv_state[sidx] = ST_OPEN;
               add_event(EV_STATE, '0, sidx);
            end
         end
      endcase
      if (pending_events.size() > n_prior) pending_events[$].last = 1;
   endtask

   always @(posedge clock) begin
      dispatch_event_type x;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected result ev=%0d tag=%h", rsp_tuser,
                                      rsp_tdata[15:0]));
         end else begin
            x = pending_events.pop_front();
            if (rsp_tuser !== x.ev)
               report_mismatch($sformatf("event %0d, want %0d", rsp_tuser, x.ev));
            if (rsp_tdata[15:0] !== x.tag)
               report_mismatch($sformatf("tag %h, want %h", rsp_tdata[15:0], x.tag));
            if (rsp_tdata[18:16] !== x.srv)
               report_mismatch($sformatf("server %0d, want %0d", rsp_tdata[18:16], x.srv));
            if (rsp_tdata[50:19] !== x.clk)
               report_mismatch($sformatf("clock %0d, want %0d", rsp_tdata[50:19], x.clk));
            if (rsp_tlast !== x.last)
               report_mismatch($sformatf("last %b, want %b", rsp_tlast, x.last));
         end
      end
   end

   // Result side: a random stall, unless no_stall is set, before each result is taken.
   initial begin
      int w;
      forever begin
         @(negedge clock);
         w = no_stall ? 0 : $urandom_range(0, 17);
         if (w > 0) begin
            rsp_tready = 0;
            repeat (w) @(negedge clock);
         end
         rsp_tready = 1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] tag,
                            input logic [SVC_W-1:0] svc, input logic [2:0] sidx);
      int w;
      w = no_stall ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (w > 0) begin
         req_tvalid = 0;
         repeat (w) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = kind;
      req_tdata = {1'b0, sidx, svc, tag};
      do @(posedge clock); while (!req_tready);
      predict_dispatch(kind, tag, svc, sidx);
   endtask

   task automatic write_servers(input logic [CSR_W-1:0] value);
      @(negedge clock);
      req_tvalid = 0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid = 1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      servers_reg = value;
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic send_random();
      int pick;
      logic [KIND_W-1:0] kind;
      logic [SVC_W-1:0] svc;
      pick = $urandom_range(0, 99);
      if (pick < 42) kind = KIND_TICK;
      else if (pick < 80) kind = KIND_ARRIVE;
      else if (pick < 90) kind = KIND_CLOSE;
      else kind = KIND_REOPEN;
      svc = ($urandom_range(0, 9) == 0) ? SVC_W'($urandom) : SVC_W'($urandom_range(0, 4));
      send_item(kind, TAG_W'($urandom), svc, 3'($urandom_range(0, 7)));
   endtask

   stim_row_type directed [19];
   logic [CSR_W-1:0] phase_setting [6] = '{4'd1, 4'd15, 4'd2, 4'd0, 4'd5, 4'd8};

   initial begin
      directed = '{
         '{KIND_ARRIVE, 16'hFFFF, 12'h000, 3'd0, 1, EV_PLACED, 3'd0},
         '{KIND_ARRIVE, 16'h0000, 12'hFFF, 3'd7, 1, EV_PLACED, 3'd1},
         '{KIND_TICK,   16'h0000, 12'h000, 3'd0, 1, EV_DEPART, 3'd0},
         '{KIND_ARRIVE, 16'h1234, 12'h002, 3'd0, 1, EV_PLACED, 3'd0},
         '{KIND_ARRIVE, 16'h00A5, 12'h001, 3'd0, 1, EV_PLACED, 3'd2},
         '{KIND_CLOSE,  16'h0000, 12'h000, 3'd7, 1, EV_STATE,  3'd7},
         '{KIND_REOPEN, 16'h0000, 12'h000, 3'd7, 1, EV_STATE,  3'd7},
         '{KIND_ARRIVE, 16'h4321, 12'h003, 3'd0, 1, EV_PLACED, 3'd3},
         '{KIND_ARRIVE, 16'h1111, 12'h000, 3'd0, 1, EV_PLACED, 3'd4},
         '{KIND_ARRIVE, 16'h2222, 12'h005, 3'd0, 0, EV_PLACED, 3'd0},
         '{KIND_ARRIVE, 16'h3333, 12'h001, 3'd0, 0, EV_PLACED, 3'd0},
         '{KIND_ARRIVE, 16'h4444, 12'h002, 3'd0, 0, EV_PLACED, 3'd0},
         '{KIND_ARRIVE, 16'h5555, 12'h003, 3'd0, 0, EV_PLACED, 3'd0},
         '{KIND_ARRIVE, 16'h6666, 12'h001, 3'd0, 0, EV_PLACED, 3'd0},
         '{KIND_CLOSE,  16'h0000, 12'h000, 3'd0, 0, EV_STATE,  3'd0},
         '{KIND_TICK,   16'h0000, 12'h000, 3'd0, 0, EV_DEPART, 3'd0},
         '{KIND_TICK,   16'h0000, 12'h000, 3'd0, 0, EV_DEPART, 3'd0},
         '{KIND_REOPEN, 16'h0000, 12'h000, 3'd0, 0, EV_STATE,  3'd0},
         '{KIND_TICK,   16'h0000, 12'h000, 3'd0, 0, EV_DEPART, 3'd0}
      };
      servers_reg = 4'd8;
      ticks = '0;
      for (int i = 0; i < NSRV; i++) begin
         srv_state[i] = ST_OPEN;
         head_ptr[i] = 0;
         tail_ptr[i] = 0;
         fill[i] = 0;
         elapsed[i] = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (directed[r]) begin
         send_item(directed[r].kind, directed[r].tag, directed[r].svc, directed[r].sidx);
         if (directed[r].typed) begin
            pending_events[$].ev = directed[r].ev;
            pending_events[$].srv = directed[r].srv;
         end
      end

      foreach (phase_setting[p]) begin
         write_servers(phase_setting[p]);
         no_stall = (p % 3 == 2);
         repeat (35) send_random();
      end

      @(negedge clock);
      req_tvalid = 0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
